// ----- sv/ght_pkg.sv -----
// ----------------------------------------------------------------------------
// ght_pkg
// Shared types and constants of the generational handle table.
// ----------------------------------------------------------------------------
package ght_pkg;

  localparam int SLOT_COUNT = 64;
  localparam int SLOT_BITS  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int GEN_SHIFT  = 16;
  localparam logic [15:0] IDX_MASK = 16'hFFFF;
  localparam int DESC_W = 2 + 32 + 31 + 31 + 64;
  // per-slot word: generation over reference count
  localparam int META_W = 16 + 32;

  typedef enum logic [1:0] {
    KIND_REGISTER = 2'd0,
    KIND_RETAIN   = 2'd1,
    KIND_RELEASE  = 2'd2,
    KIND_QUERY    = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BAD_ARG    = 3'd1,
    ST_NO_MEM     = 3'd2,
    ST_BAD_HANDLE = 3'd3,
    ST_BAD_REQ    = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_READ,
    BK_WRITE
  } bk_state_t;

  // one classified request, front to back
  typedef struct packed {
    kind_t                 kind;
    logic                  early;      // answer known without table
    status_t               early_st;
    logic [SLOT_BITS-1:0]  slot;
    logic [15:0]           gen;
    logic                  teardown_ok;
    logic [DESC_W-1:0]     desc;
  } req_t;

endpackage

// ----- sv/ght_ram.sv -----
// ----------------------------------------------------------------------------
// ght_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module ght_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

// ----- sv/ght_front.sv -----
// ----------------------------------------------------------------------------
// ght_front
// Accepts requests, checks arguments and handle range, queues them.
// ----------------------------------------------------------------------------
module ght_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  logic [1:0]     kind,
  input  logic [31:0]    handle,
  input  logic [1:0]     api,
  input  logic [31:0]    device_id,
  input  logic [30:0]    width,
  input  logic [30:0]    height,
  input  logic [63:0]    image_word,
  input  logic           teardown_ok,
  output ght_pkg::req_t  req,
  output logic           req_valid,
  input  logic           req_take
);
  import ght_pkg::*;

  // two-entry queue
  req_t q0, q1;
  logic [1:0] cnt;
  req_t in_req;
  logic [15:0] idx;
  logic push;

  assign idx  = handle[15:0] & IDX_MASK;
  assign busy = (cnt == 2'd2);
  assign push = start && !busy;

  // classify
  always_comb begin
    in_req             = '0;
    in_req.kind        = kind_t'(kind);
    in_req.gen         = handle[31:GEN_SHIFT];
    in_req.slot        = SLOT_BITS'(idx - 16'd1);
    in_req.teardown_ok = teardown_ok;
    in_req.desc        = {api, device_id, width, height, image_word};
    in_req.early_st    = ST_OK;
    if (kind_t'(kind) == KIND_REGISTER) begin
      if (device_id == '0 || width == '0 || height == '0 ||
          image_word == '0 || api == 2'd3) begin
        in_req.early    = 1'b1;
        in_req.early_st = ST_BAD_ARG;
      end
    end else if (idx == '0 || handle[31:GEN_SHIFT] == '0 ||
                 32'(idx) > 32'(SLOT_COUNT)) begin
      in_req.early    = 1'b1;
      in_req.early_st = ST_BAD_HANDLE;
    end
  end

  assign req       = q0;
  assign req_valid = (cnt != 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      case ({push, req_take && req_valid})
        2'b10: begin
          if (cnt == 2'd0) q0 <= in_req; else q1 <= in_req;
          cnt <= cnt + 2'd1;
        end
        2'b01: begin
          q0  <= q1;
          cnt <= cnt - 2'd1;
        end
        2'b11: begin
          if (cnt == 2'd1) q0 <= in_req;
          else begin
            q0 <= q1;
            q1 <= in_req;
          end
        end
        default: ;
      endcase
    end
  end
endmodule

// ----- sv/ght_back.sv -----
// ----------------------------------------------------------------------------
// ght_back
// Executes queued requests against the slot table and drives results.
// ----------------------------------------------------------------------------
module ght_back (
  input  logic           clk,
  input  logic           rst,
  input  ght_pkg::req_t  req,
  input  logic           req_valid,
  output logic           req_take,
  output logic           done,
  output logic [2:0]     status,
  output logic [31:0]    new_handle,
  output logic [1:0]     info_api,
  output logic [31:0]    info_device,
  output logic [30:0]    info_width,
  output logic [30:0]    info_height,
  output logic [63:0]    info_backend
);
  import ght_pkg::*;

  // count and generation share one RAM word per slot, descriptor in another
  // RAM; occupancy and generation-written bits stand in for reset values
  logic [SLOT_COUNT-1:0] used;
  logic [SLOT_COUNT-1:0] gen_valid;

  bk_state_t state, state_next;
  req_t cur;

  logic [SLOT_BITS-1:0] free_slot;
  logic                 free_found;
  logic                 live;
  logic [31:0]          cnt_s;
  logic [15:0]          gen_s;
  logic [15:0]          gen_inc;
  logic [SLOT_BITS-1:0] ram_addr;
  logic                 meta_we;
  logic                 desc_we;
  logic [META_W-1:0]    meta_wdata;
  logic [META_W-1:0]    meta_rdata;
  logic [DESC_W-1:0]    desc_rdata;
  logic                 used_set;
  logic                 used_clr;
  status_t              res_status;
  logic [31:0]          res_handle;
  logic                 res_query;

  // lowest free slot
  always_comb begin
    free_slot  = '0;
    free_found = 1'b0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (!used[i]) begin
        free_slot  = SLOT_BITS'(i);
        free_found = 1'b1;
      end
    end
  end

  // same slot for the read and the write back; cur and used hold meanwhile
  assign ram_addr = (cur.kind == KIND_REGISTER) ? free_slot : cur.slot;

  assign cnt_s   = meta_rdata[31:0];
  assign gen_s   = gen_valid[ram_addr] ? meta_rdata[META_W-1:32] : 16'd1;
  assign live    = used[ram_addr] && (gen_s == cur.gen);
  assign gen_inc = (gen_s == 16'hFFFF) ? 16'd1 : gen_s + 16'd1;

  ght_ram #(.WIDTH(META_W), .DEPTH(SLOT_COUNT)) u_meta (
    .clk   (clk),
    .we    (meta_we),
    .addr  (ram_addr),
    .wdata (meta_wdata),
    .rdata (meta_rdata)
  );

  ght_ram #(.WIDTH(DESC_W), .DEPTH(SLOT_COUNT)) u_desc (
    .clk   (clk),
    .we    (desc_we),
    .addr  (ram_addr),
    .wdata (cur.desc),
    .rdata (desc_rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE:  if (req_valid) state_next = BK_READ;
      BK_READ:  state_next = BK_WRITE;
      BK_WRITE: state_next = req_valid ? BK_READ : BK_IDLE;
      default:  state_next = BK_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    req_take = 1'b0;
    case (state)
      BK_IDLE:  req_take = req_valid;
      BK_READ:  req_take = 1'b0;
      BK_WRITE: req_take = req_valid;
      default:  req_take = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (req_take) cur <= req;
  end

  // decision and write back, from the word read in the previous cycle
  always_comb begin
    res_status = ST_OK;
    res_handle = '0;
    res_query  = 1'b0;
    meta_we    = 1'b0;
    desc_we    = 1'b0;
    meta_wdata = {gen_s, cnt_s};
    used_set   = 1'b0;
    used_clr   = 1'b0;
    if (cur.early) begin
      res_status = cur.early_st;
    end else begin
      case (cur.kind)
        KIND_REGISTER: begin
          if (!free_found) res_status = ST_NO_MEM;
          else begin
            meta_we    = 1'b1;
            desc_we    = 1'b1;
            meta_wdata = {gen_s, 32'd1};
            used_set   = 1'b1;
            res_handle = {gen_s, 16'(ram_addr) + 16'd1};
          end
        end
        KIND_RETAIN: begin
          if (!live) res_status = ST_BAD_HANDLE;
          else if (cnt_s == 32'hFFFF_FFFF) res_status = ST_BAD_REQ;
          else begin
            meta_we    = 1'b1;
            meta_wdata = {gen_s, cnt_s + 32'd1};
          end
        end
        KIND_RELEASE: begin
          if (!live) res_status = ST_BAD_HANDLE;
          else if (cnt_s > 32'd1) begin
            meta_we    = 1'b1;
            meta_wdata = {gen_s, cnt_s - 32'd1};
          end else if (!cur.teardown_ok) begin
            res_status = ST_BAD_REQ;
          end else begin
            // last reference gone: free the slot, next generation
            meta_we    = 1'b1;
            meta_wdata = {gen_inc, 32'd0};
            used_clr   = 1'b1;
          end
        end
        default: begin
          if (!live) res_status = ST_BAD_HANDLE;
          else res_query = 1'b1;
        end
      endcase
    end
    if (state != BK_WRITE) begin
      meta_we  = 1'b0;
      desc_we  = 1'b0;
      used_set = 1'b0;
      used_clr = 1'b0;
    end
  end

  // state, occupancy and strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      done      <= 1'b0;
      used      <= '0;
      gen_valid <= '0;
    end else begin
      state <= state_next;
      done  <= (state == BK_WRITE);
      if (used_set) used[ram_addr] <= 1'b1;
      else if (used_clr) used[ram_addr] <= 1'b0;
      if (meta_we) gen_valid[ram_addr] <= 1'b1;
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (state == BK_WRITE) begin
      status     <= res_status;
      new_handle <= res_handle;
      {info_api, info_device, info_width, info_height, info_backend} <=
        res_query ? desc_rdata : '0;
    end
  end
endmodule

// ----- sv/generational_handle_table.sv -----
// ----------------------------------------------------------------------------
// generational_handle_table
// Reference-counted slot table addressed by generational handles.
// ----------------------------------------------------------------------------
// Channel  Handshake          Payload
// request  start / !busy      kind handle api device_id width height
//                             image_word teardown_ok
// result   done (one cycle)   status new_handle info_*
//
// done rises after the queue take, the registered table read and the write
// back. Fed from a full queue, the back part takes the next request in the
// write-back state of the last one. Requests go through a two-entry queue;
// busy rises only when it is full. The receiver cannot stall. Reset is
// synchronous and clears occupancy and generation-written bits at once, so
// all slots read free and generations one.
module generational_handle_table (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  kind,
  input  logic [31:0] handle,
  input  logic [1:0]  api,
  input  logic [31:0] device_id,
  input  logic [30:0] width,
  input  logic [30:0] height,
  input  logic [63:0] image_word,
  input  logic        teardown_ok,
  output logic        done,
  output logic [2:0]  status,
  output logic [31:0] new_handle,
  output logic [1:0]  info_api,
  output logic [31:0] info_device,
  output logic [30:0] info_width,
  output logic [30:0] info_height,
  output logic [63:0] info_backend
);
  import ght_pkg::*;

  req_t req;
  logic req_valid, req_take;

  ght_front u_front (
    .clk, .rst, .start, .busy, .kind, .handle, .api, .device_id, .width,
    .height, .image_word, .teardown_ok,
    .req (req), .req_valid (req_valid), .req_take (req_take)
  );

  ght_back u_back (
    .clk, .rst, .req (req), .req_valid (req_valid), .req_take (req_take),
    .done, .status, .new_handle, .info_api, .info_device, .info_width,
    .info_height, .info_backend
  );
endmodule

// ----- tb/sv/generational_handle_table_test.sv -----
// ----------------------------------------------------------------------------
// generational_handle_table_test
// Self-checking bench for the generational handle table: directed cases for
// argument checks, full table, stale and malformed handles and final
// release with and without teardown, then random request streams driven
// mostly from the live handle set.
// ----------------------------------------------------------------------------
module generational_handle_table_test;
  import ght_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_COUNT_HITS = 4;

  typedef struct {
    status_t     st;
    logic [31:0] nh;
    logic [1:0]  api;
    logic [31:0] dev;
    logic [30:0] w;
    logic [30:0] h;
    logic [63:0] be;
  } answer_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  kind = '0;
  logic [31:0] handle = '0;
  logic [1:0]  api = '0;
  logic [31:0] device_id = '0;
  logic [30:0] width = '0;
  logic [30:0] height = '0;
  logic [63:0] image_word = '0;
  logic        teardown_ok = 1'b0;
  logic        done;
  logic [2:0]  status;
  logic [31:0] new_handle;
  logic [1:0]  info_api;
  logic [31:0] info_device;
  logic [30:0] info_width;
  logic [30:0] info_height;
  logic [63:0] info_backend;

  generational_handle_table DUT (.*);

  always #2 clk = ~clk;

  // predictor state
  logic [15:0] gen_tbl [SLOT_COUNT];
  logic [31:0] cnt_tbl [SLOT_COUNT];
  logic [1:0]  api_tbl [SLOT_COUNT];
  logic [31:0] dev_tbl [SLOT_COUNT];
  logic [30:0] w_tbl   [SLOT_COUNT];
  logic [30:0] h_tbl   [SLOT_COUNT];
  logic [63:0] be_tbl  [SLOT_COUNT];

  answer_t     pending_answers[$];
  logic [31:0] live_handles[$];
  logic [31:0] dead_handles[$];
  int          errors = 0;

  // table update and answer for one accepted request
  function automatic answer_t predict_answer(kind_t k, logic [31:0] hd, logic [1:0] a,
      logic [31:0] d, logic [30:0] w, logic [30:0] h, logic [63:0] b, logic tok);
    answer_t r;
    int s;
    logic [15:0] gi, gg;
    r = '{ST_OK, '0, '0, '0, '0, '0, '0};
    if (k == KIND_REGISTER) begin
      if (d == 0 || w == 0 || h == 0 || b == 0 || a == 2'd3) begin
        r.st = ST_BAD_ARG;
        return r;
      end
      s = -1;
      for (int i = SLOT_COUNT - 1; i >= 0; i--) if (cnt_tbl[i] == 0) s = i;
      if (s < 0) begin
        r.st = ST_NO_MEM;
        return r;
      end
      cnt_tbl[s] = 1; api_tbl[s] = a; dev_tbl[s] = d;
      w_tbl[s] = w; h_tbl[s] = h; be_tbl[s] = b;
      r.nh = {gen_tbl[s], 16'(s + 1)};
      return r;
    end
    gi = hd[15:0];
    gg = hd[31:16];
    if (gi == 0 || gg == 0 || gi > SLOT_COUNT) begin
      r.st = ST_BAD_HANDLE;
      return r;
    end
    s = gi - 1;
    if (cnt_tbl[s] == 0 || gen_tbl[s] != gg) begin
      r.st = ST_BAD_HANDLE;
      return r;
    end
    case (k)
      KIND_RETAIN: begin
        if (cnt_tbl[s] == 32'hFFFF_FFFF) r.st = ST_BAD_REQ;
        else cnt_tbl[s]++;
      end
      KIND_RELEASE: begin
        if (cnt_tbl[s] > 1) cnt_tbl[s]--;
        else if (!tok) r.st = ST_BAD_REQ;
        else begin
          cnt_tbl[s] = 0;
          gen_tbl[s] = gen_tbl[s] + 16'd1;
          if (gen_tbl[s] == 0) gen_tbl[s] = 16'd1;
        end
      end
      default: begin
        r.api = api_tbl[s]; r.dev = dev_tbl[s]; r.w = w_tbl[s];
        r.h = h_tbl[s]; r.be = be_tbl[s];
      end
    endcase
    return r;
  endfunction

  // keep the handle pools in step with the table
  function automatic void track_handles(kind_t k, logic [31:0] hd, answer_t r);
    if (k == KIND_REGISTER && r.st == ST_OK) live_handles.push_back(r.nh);
    if (k == KIND_RELEASE && r.st == ST_OK && cnt_tbl[hd[15:0] - 1] == 0) begin
      foreach (live_handles[i]) if (live_handles[i] == hd) begin
        live_handles.delete(i);
        break;
      end
      dead_handles.push_back(hd);
    end
  endfunction

  // one beat in; the random gap before it unless no_gap
  task automatic send_request(kind_t k, logic [31:0] hd, logic [1:0] a, logic [31:0] d,
      logic [30:0] w, logic [30:0] h, logic [63:0] b, logic tok, bit no_gap = 0);
    answer_t r;
    int gap;
    gap = 0;
    if (!no_gap) begin
      case ($urandom_range(0, 9))
        0, 1, 2: gap = $urandom_range(1, 3);
        3: gap = $urandom_range(5, 30);
        default: gap = 0;
      endcase
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    kind <= k; handle <= hd; api <= a; device_id <= d;
    width <= w; height <= h; image_word <= b; teardown_ok <= tok;
    @(posedge clk);
    while (busy) @(posedge clk);
    r = predict_answer(k, hd, a, d, w, h, b, tok);
    pending_answers.push_back(r);
    track_handles(k, hd, r);
  endtask

  task automatic idle_bus();
    start <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic send_register(logic [1:0] a = 2'($urandom_range(0, 2)));
    send_request(KIND_REGISTER, $urandom(), a, $urandom_range(1, 32'hFFFF_FFFF),
                 31'($urandom_range(1, 32'h7FFF_FFFF)),
                 31'($urandom_range(1, 32'h7FFF_FFFF)), rand64() | 64'd1,
                 1'($urandom()));
  endtask

  // result checking
  always @(posedge clk) begin
    answer_t x;
    if (!rst && done) begin
      if (pending_answers.size() == 0) begin
        $display("%0t: unexpected result beat status=%0d", $time, status);
        errors++;
      end else begin
        x = pending_answers.pop_front();
        if (status !== x.st || new_handle !== x.nh || info_api !== x.api ||
            info_device !== x.dev || info_width !== x.w || info_height !== x.h ||
            info_backend !== x.be) begin
          $display("%0t: mismatch expected st=%0d nh=%h api=%0d dev=%h w=%h h=%h be=%h",
                   $time, x.st, x.nh, x.api, x.dev, x.w, x.h, x.be);
          $display("%0t:          actual   st=%0d nh=%h api=%0d dev=%h w=%h h=%h be=%h",
                   $time, status, new_handle, info_api, info_device, info_width,
                   info_height, info_backend);
          errors++;
        end
      end
    end
  end

  // bad arguments, extremes of the descriptor fields, malformed handles
  task automatic test_arguments();
    send_request(KIND_REGISTER, 0, 2'd3, 1, 1, 1, 1, 0);
    send_request(KIND_REGISTER, 0, 0, 0, 1, 1, 1, 0);
    send_request(KIND_REGISTER, 0, 0, 1, 0, 1, 1, 0);
    send_request(KIND_REGISTER, 0, 0, 1, 1, 0, 1, 0);
    send_request(KIND_REGISTER, 0, 0, 1, 1, 1, 0, 0);
    send_request(KIND_REGISTER, '1, 2'd2, '1, '1, '1, '1, 1);
    send_request(KIND_REGISTER, 0, 2'd0, 1, 1, 1, 1, 0);
    send_request(KIND_QUERY, 32'h0001_0001, 0, 0, 0, 0, 0, 0);
    send_request(KIND_QUERY, 32'h0001_0002, 0, 0, 0, 0, 0, 0);
    send_request(KIND_RETAIN, 32'h0000_0001, 0, 0, 0, 0, 0, 0);
    send_request(KIND_RETAIN, 32'h0001_0000, 0, 0, 0, 0, 0, 0);
    send_request(KIND_RETAIN, 32'h0001_0041, 0, 0, 0, 0, 0, 0);
    send_request(KIND_QUERY, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0);
    send_request(KIND_RELEASE, 32'h0002_0001, 0, 0, 0, 0, 0, 1);
    send_request(KIND_RELEASE, 32'h0001_0003, 0, 0, 0, 0, 0, 1);
  endtask

  // retain/release counting, failed and successful teardown, stale handle
  task automatic test_lifecycle();
    logic [31:0] hd;
    send_register(2'd1);
    hd = live_handles[live_handles.size() - 1];
    send_request(KIND_RETAIN, hd, 0, 0, 0, 0, 0, 0);
    send_request(KIND_RELEASE, hd, 0, 0, 0, 0, 0, 0);
    send_request(KIND_RELEASE, hd, 0, 0, 0, 0, 0, 0);
    send_request(KIND_QUERY, hd, 0, 0, 0, 0, 0, 0);
    send_request(KIND_RELEASE, hd, 0, 0, 0, 0, 0, 1);
    send_request(KIND_QUERY, hd, 0, 0, 0, 0, 0, 0);
    send_request(KIND_RETAIN, hd, 0, 0, 0, 0, 0, 0);
    send_register(2'd2);
  endtask

  // fill the table, overflow it, then free a few
  task automatic test_table_full();
    while (live_handles.size() < SLOT_COUNT) send_register();
    send_register();
    send_register();
    repeat (4)
      send_request(KIND_RELEASE, live_handles[$urandom_range(0, live_handles.size() - 1)],
                   0, 0, 0, 0, 0, 1);
  endtask

  // random mix, biased toward live handles; back-to-back bursts included
  task automatic test_random(int n);
    logic [31:0] hd;
    int sel;
    bit burst;
    for (int i = 0; i < n; i++) begin
      burst = (i % 100) < 20;
      sel = $urandom_range(0, 99);
      if (sel < 25 || live_handles.size() == 0) begin
        if ($urandom_range(0, 9) == 0)
          send_request(KIND_REGISTER, $urandom(), 2'($urandom()),
                       $urandom_range(0, 1) * $urandom(),
                       31'($urandom_range(0, 1) * $urandom()),
                       31'($urandom_range(0, 1) * $urandom()),
                       $urandom_range(0, 1) * rand64(), 1'($urandom()), burst);
        else if (live_handles.size() < SLOT_COUNT || $urandom_range(0, 3) == 0)
          send_request(KIND_REGISTER, $urandom(), 2'($urandom_range(0, 2)),
                       $urandom_range(1, 32'hFFFF_FFFF), 31'($urandom_range(1, 32'h7FFF_FFFF)),
                       31'($urandom_range(1, 32'h7FFF_FFFF)), rand64() | 64'h8000_0000_0000_0000,
                       1'($urandom()), burst);
        else
          send_request(KIND_RELEASE, live_handles[0], 0, 0, 0, 0, 0, 1, burst);
      end else if (sel < 85) begin
        hd = live_handles[$urandom_range(0, live_handles.size() - 1)];
        send_request(kind_t'($urandom_range(1, 3)), hd, 2'($urandom()), $urandom(),
                     31'($urandom()), 31'($urandom()), rand64(),
                     $urandom_range(0, 3) != 0, burst);
      end else if (sel < 93 && dead_handles.size() > 0) begin
        hd = dead_handles[$urandom_range(0, dead_handles.size() - 1)];
        send_request(kind_t'($urandom_range(1, 3)), hd, 0, 0, 0, 0, 0, 1, burst);
      end else begin
        send_request(kind_t'($urandom_range(0, 3)), $urandom(), 2'($urandom()), $urandom(),
                     31'($urandom()), 31'($urandom()), rand64(), 1'($urandom()), burst);
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int i = 0; i < SLOT_COUNT; i++) begin
      gen_tbl[i] = 16'd1; cnt_tbl[i] = 0; api_tbl[i] = 0; dev_tbl[i] = 0;
      w_tbl[i] = 0; h_tbl[i] = 0; be_tbl[i] = 0;
    end
    test_arguments();
    test_lifecycle();
    test_table_full();
    test_random(760);
    idle_bus();
    while (pending_answers.size() > 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0)
      $display("generational_handle_table_test: PASS");
    else
      $display("generational_handle_table_test: FAIL");
    $finish;
  end

  initial begin
    #2ms;
    $display("generational_handle_table_test: FAIL");
    $finish;
  end
endmodule
